>>> src/hsfrg_pkg.sv
// ----------------------------------------------------------------------------
// hsfrg_pkg: shared types and constants of the site rate gate
// Slot layout, controller states, command/status bundles, fixed constants.
// ----------------------------------------------------------------------------
package hsfrg_pkg;

	localparam int unsigned SRC_W = 32;
	localparam int unsigned FRM_W = 32;
	localparam int unsigned RAT_W = 17;
	localparam int unsigned FRAC_W = 16;              // Q1.16 fraction bits
	localparam int unsigned PROD_W = FRM_W + RAT_W;

	localparam int unsigned S_TDATA_W = 88;           // 81 field bits padded to bytes
	localparam int unsigned M_TDATA_W = 8;

	localparam logic [RAT_W-1:0] Q_ONE = 17'h10000;

	// hash: key = (s ^ (s >> 4)) * golden multiplier, bits above 8
	localparam logic [SRC_W-1:0] HASH_MULT = 32'd2654435761;
	localparam int unsigned HASH_SHIFT = 4;
	localparam int unsigned KEY_LSB = 8;
	localparam int unsigned HKEY_W = SRC_W - KEY_LSB;

	// slot index reduction: reciprocal quotient estimate, then multiply-back and fix-up
	localparam int unsigned MOD_STEPS = 2;
	localparam int unsigned MSTEP_W = $clog2(MOD_STEPS);

	typedef struct packed {
		logic [SRC_W-1:0] source;
		logic [FRM_W-1:0] last_frame;
		logic [RAT_W-1:0] carry;
		logic             open;
	} slot_t;

	localparam slot_t SLOT_EMPTY = '{source: '0, last_frame: '0, carry: '0, open: 1'b1};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_PROBE,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic load_in;
		logic hash_go;
		logic mod_step;
		logic probe_start;
		logic probe_run;
		logic mul_go;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic zero_src;
		logic mod_last;
		logic probe_hit;
		logic probe_miss;
		logic out_free;
	} sts_t;

endpackage

>>> src/hsfrg_ctrl.sv
// ----------------------------------------------------------------------------
// hsfrg_ctrl: sequencing controller of the site rate gate
// Steps the datapath through clear, hash, index reduction, probe, decide.
// ----------------------------------------------------------------------------
module hsfrg_ctrl import hsfrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_HASH;
			end
			ST_HASH: begin
				state_nx = sts.zero_src ? ST_DONE : ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_last) state_nx = ST_PROBE;
			end
			ST_PROBE: begin
				priority if (sts.probe_hit) state_nx = ST_MUL;
				else if (sts.probe_miss) state_nx = ST_DONE;
			end
			ST_MUL: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_HASH: cmd.hash_go = 1'b1;
			ST_MOD: begin
				cmd.mod_step    = 1'b1;
				cmd.probe_start = sts.mod_last;
			end
			ST_PROBE: cmd.probe_run = 1'b1;
			ST_MUL:   cmd.mul_go = 1'b1;
			ST_DONE:  cmd.finish = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> src/hsfrg_dp.sv
// ----------------------------------------------------------------------------
// hsfrg_dp: datapath of the site rate gate
// Slot memory, hash multiplier, index reduction, probe compare, carry logic
// and the output register.
// ----------------------------------------------------------------------------
module hsfrg_dp import hsfrg_pkg::*; #(
	parameter int unsigned SITE_SLOTS  = 256,
	parameter int unsigned PROBE_LIMIT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int unsigned IDX_W = $clog2(SITE_SLOTS);
	localparam int unsigned CNT_W = $clog2(PROBE_LIMIT + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SITE_SLOTS - 1);
	localparam logic [IDX_W:0] SLOTS_N = (IDX_W + 1)'(SITE_SLOTS);
	localparam logic [CNT_W-1:0] PROBE_END = CNT_W'(PROBE_LIMIT);
	localparam logic [HKEY_W-1:0] RECIP = HKEY_W'((64'd1 << HKEY_W) / 64'(SITE_SLOTS));
	localparam logic [HKEY_W-1:0] SLOTS_K = HKEY_W'(SITE_SLOTS);

	slot_t slot_mem [SITE_SLOTS];

	logic [SRC_W-1:0]   src_q;
	logic [FRM_W-1:0]   frame_q;
	logic [RAT_W-1:0]   ratio_q;
	logic [HKEY_W-1:0]  hkey_q;
	logic [HKEY_W-1:0]  quo_q;
	logic [MSTEP_W-1:0] mstep_q;
	logic [IDX_W-1:0]   issue_idx_q;
	logic [CNT_W-1:0]   issue_cnt_q;
	logic               rd_pend_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	slot_t              rd_data_s1;
	slot_t              ent_q;
	logic [IDX_W-1:0]   slot_q;
	logic               trk_q;
	logic [PROD_W-1:0]  prod_q;
	logic [IDX_W-1:0]   clr_q;
	logic               m_tvalid_q;
	logic               emit_q;
	logic               trkout_q;

	logic [SRC_W-1:0]    mix;
	logic [SRC_W-1:0]    hkey_full;
	logic [2*HKEY_W-1:0] qprod;
	logic [HKEY_W-1:0]   qn;
	logic [HKEY_W-1:0]   rem_wide;
	logic [IDX_W-1:0]    rem_nx;
	logic [IDX_W:0]      rem_t;
	logic [RAT_W-1:0]    ratio_in;
	logic                rd_match;
	logic                rd_empty;
	logic [FRM_W-1:0]    elapsed;
	logic [PROD_W-1:0]   prod_nx;
	logic                same_frame;
	logic                fresh;
	logic [RAT_W:0]      csum;
	logic                cwrap;
	logic [RAT_W:0]      cnew;
	slot_t               new_ent;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	slot_t               mem_wd;

	// input capture, ratio saturates to 1.0 (zero also means 1.0)
	assign ratio_in = s_tdata[SRC_W+FRM_W +: RAT_W];

	// hash
	assign mix       = src_q ^ (src_q >> HASH_SHIFT);
	assign hkey_full = mix * HASH_MULT;

	// key mod SITE_SLOTS: quotient estimate from the reciprocal (low by at
	// most one), multiply back, one compare-subtract
	assign qprod    = (2*HKEY_W)'(hkey_q) * (2*HKEY_W)'(RECIP);
	assign qn       = quo_q * SLOTS_K;
	assign rem_wide = hkey_q - qn;

	always_comb begin
		rem_t = rem_wide[IDX_W:0];
		if (rem_t >= SLOTS_N) rem_t = rem_t - SLOTS_N;
		rem_nx = rem_t[IDX_W-1:0];
	end

	// probe compare on registered read data
	assign rd_match = rd_data_s1.source == src_q;
	assign rd_empty = rd_data_s1.source == '0;

	// decision
	assign elapsed    = frame_q - ent_q.last_frame;
	assign prod_nx    = PROD_W'(elapsed) * PROD_W'(ratio_q);
	assign same_frame = ent_q.last_frame == frame_q;
	assign fresh      = (ent_q.last_frame == '0) || (|prod_q[PROD_W-1:FRAC_W]);
	assign csum       = {1'b0, ent_q.carry} + {1'b0, ratio_q};
	assign cwrap      = csum >= {1'b0, Q_ONE};
	assign cnew       = cwrap ? (csum - {1'b0, Q_ONE}) : csum;

	always_comb begin
		new_ent        = ent_q;
		new_ent.source = src_q;
		priority if (same_frame) begin
			new_ent.source = src_q;
		end else if (fresh) begin
			new_ent.last_frame = frame_q;
			new_ent.carry      = '0;
			new_ent.open       = 1'b1;
		end else begin
			new_ent.last_frame = frame_q;
			new_ent.carry      = cnew[RAT_W-1:0];
			new_ent.open       = cwrap;
		end
	end

	// single write port: clear sweep or write-back
	assign mem_we = cmd.clr_en | (cmd.finish & trk_q);
	assign mem_wa = cmd.clr_en ? clr_q : slot_q;
	assign mem_wd = cmd.clr_en ? SLOT_EMPTY : new_ent;

	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[mem_wa] <= mem_wd;
		rd_data_s1 <= slot_mem[issue_idx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			src_q   <= s_tdata[0 +: SRC_W];
			frame_q <= s_tdata[SRC_W +: FRM_W];
			ratio_q <= ((ratio_in == '0) || (ratio_in > Q_ONE)) ? Q_ONE : ratio_in;
		end
		if (cmd.hash_go) hkey_q <= hkey_full[KEY_LSB +: HKEY_W];
		if (cmd.mod_step) quo_q <= qprod[HKEY_W +: HKEY_W];
		if (cmd.probe_start) begin
			issue_idx_q <= rem_nx;
		end else if (cmd.probe_run && (issue_cnt_q != PROBE_END)) begin
			issue_idx_q <= (issue_idx_q == IDX_LAST) ? '0 : issue_idx_q + 1'b1;
			rd_idx_s1   <= issue_idx_q;
		end
		if (cmd.probe_run && sts.probe_hit) begin
			slot_q <= rd_idx_s1;
			ent_q  <= rd_empty ? slot_t'{source: src_q, last_frame: '0, carry: '0, open: 1'b1}
			                   : rd_data_s1;
		end
		if (cmd.mul_go) prod_q <= prod_nx;
		if (cmd.finish) begin
			emit_q   <= trk_q ? new_ent.open : 1'b1;
			trkout_q <= trk_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			mstep_q     <= '0;
			issue_cnt_q <= '0;
			rd_pend_s1  <= 1'b0;
			trk_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + 1'b1;
			if (cmd.hash_go) mstep_q <= '0;
			else if (cmd.mod_step) mstep_q <= mstep_q + 1'b1;
			if (cmd.probe_start) begin
				issue_cnt_q <= '0;
				rd_pend_s1  <= 1'b0;
			end else if (cmd.probe_run) begin
				if (issue_cnt_q != PROBE_END) begin
					issue_cnt_q <= issue_cnt_q + 1'b1;
					rd_pend_s1  <= 1'b1;
				end else begin
					rd_pend_s1 <= 1'b0;
				end
			end
			if (cmd.load_in) trk_q <= 1'b0;
			else if (cmd.probe_run && sts.probe_hit) trk_q <= 1'b1;
			if (cmd.finish) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_done   = cmd.clr_en && (clr_q == IDX_LAST);
		sts.zero_src   = src_q == '0;
		sts.mod_last   = mstep_q == MSTEP_W'(MOD_STEPS - 1);
		sts.probe_hit  = rd_pend_s1 && (rd_match || rd_empty);
		sts.probe_miss = !rd_pend_s1 && (issue_cnt_q == PROBE_END);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, trkout_q, emit_q};

endmodule

>>> src/hashed_site_fractional_rate_gate_core.sv
// ----------------------------------------------------------------------------
// hashed_site_fractional_rate_gate_core: per-source emission rate gate
// Finds or claims a hashed table slot for each source and decides, with a
// Q1.16 fractional carry, whether the source may emit on the current frame.
// ----------------------------------------------------------------------------
// Accept to m_tvalid takes longer the later the probe that finds the source,
//   and longest when the probe window is exhausted; source zero goes from HASH
//   straight to DONE. The probe walk over the slot memory read port sets the
//   spread. One request is handled at a time; the next request is taken while
//   the result waits in the output reg.
// Reset: arst_n clears control state, then a clearing sweep writes every slot
//   empty with s_tready low.
//
// Flow per request:
//   HASH  - key = (src ^ src >> 4) * 2654435761, registered.
//   MOD   - key bits [31:8] modulo SITE_SLOTS: reciprocal quotient estimate,
//           then multiply-back and one fix-up subtract.
//   PROBE - one slot read issued a cycle, compared on the registered data;
//           first slot holding the source, or first empty one, wins.
//   MUL   - elapsed frames times ratio, registered (idle test: >= 1.0).
//   DONE  - decision, slot write-back for a tracked source and load of the output register.
module hashed_site_fractional_rate_gate_core import hsfrg_pkg::*; #(
	parameter int unsigned SITE_SLOTS  = 256,
	parameter int unsigned PROBE_LIMIT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] site_address, [63:32] frame_number,
	                                        // [80:64] time_ratio, [87:81] zero
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [0] may_emit, [1] tracked, [7:2] zero
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	hsfrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot table, hash, decision, output register
	hsfrg_dp #(
		.SITE_SLOTS  (SITE_SLOTS),
		.PROBE_LIMIT (PROBE_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// one request in flight: no accept right after an accept
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous request in flight");

	// a result appears only through the finish command
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.finish))
		else $error("result valid without finish");

	// finish never overwrites a result that is still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("finish while output register busy");

	// the clearing sweep never overlaps request intake
	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> !s_tready)
		else $error("request intake during clearing sweep");

endmodule
